>>> design/mtfl_pkg.sv
// Shared constants and types for the move-to-front list search block.
`default_nettype none

package mtfl_pkg;

	// Number of cells in the list; every list size is clamped to this.
	localparam int MAX_ITEMS = 256;

	// Width of a stored key and of the active list size (holds MAX_ITEMS).
	localparam int KEY_W = $clog2(MAX_ITEMS + 1);

	// Fixed port widths.
	localparam int IN_W  = 9;
	localparam int POS_W = 9;
	localparam int TOT_W = 32;

	// Scan counter: counts up to two past the last position.
	localparam int CNT_W = $clog2(MAX_ITEMS + 3);

	// Hit flags are gathered in registered groups of this many cells.
	localparam int GRP  = 16;
	localparam int NGRP = (MAX_ITEMS + GRP - 1) / GRP;

	// Operation codes.
	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_INIT   = 1'b1;

	// List size after reset.
	localparam logic [IN_W-1:0] RST_SIZE = IN_W'(256);

	// Controls from the sequencer to the row of cells.
	typedef struct packed {
		logic             ld;
		logic [KEY_W-1:0] size;
		logic             inj;
		logic [KEY_W-1:0] key;
	} mtfl_ctl_t;

endpackage

`default_nettype wire

>>> design/move_to_front_list_search.sv
// Reinitialize and out-of-range keys give their result in the cycle after start;
// a found key's result passes the cell hit flag, the group register and done_q.
// Throughput: one item at a time; busy falls as the result strobe rises, so start
// may be taken in the strobe cycle. The scan walks the row of cells one per cycle.
// Reset: list holds keys ascending up to 256, total is zero; busy stays high after
// reset while the cells load.
`default_nettype none

module move_to_front_list_search (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire                          op,
	input  wire  [mtfl_pkg::IN_W-1:0]    key,
	output logic                         done,
	output logic [mtfl_pkg::POS_W-1:0]   position_cost,
	output logic                         found,
	output logic [mtfl_pkg::TOT_W-1:0]   total_cost,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [mtfl_pkg::IN_W-1:0]    cfg_data
);
	import mtfl_pkg::*;

	localparam int CMP_W = (KEY_W > IN_W) ? KEY_W : IN_W;

	logic [IN_W-1:0]   size_q;
	logic [KEY_W-1:0]  active_q;
	logic [TOT_W-1:0]  total_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [POS_W-1:0]  pos_q;
	logic              found_q;
	logic              done_q;
	logic              busy_q;
	logic              pend_q;
	logic              accept;
	logic              in_range;
	logic              chain_hit;
	logic [KEY_W-1:0]  new_size;
	logic [CNT_W-1:0]  pos_full;
	logic [TOT_W:0]    sum;
	mtfl_ctl_t         ctl;

	// Clamp a written list size to one through MAX_ITEMS.
	function automatic logic [KEY_W-1:0] clamp_size(input logic [IN_W-1:0] s);
		logic [KEY_W-1:0] r;
		if (s == '0) begin
			r = KEY_W'(1);
		end else if (CMP_W'(s) > CMP_W'(MAX_ITEMS)) begin
			r = KEY_W'(MAX_ITEMS);
		end else begin
			r = KEY_W'(s);
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign busy      = busy_q || pend_q;
	assign accept    = start && !busy;
	assign in_range  = (key != '0) && (CMP_W'(key) <= CMP_W'(active_q));
	assign new_size  = pend_q ? clamp_size(RST_SIZE) : clamp_size(size_q);

	// Position is two behind the counter once the gathered hit arrives.
	assign pos_full = cnt_q - CNT_W'(2);
	assign sum      = {1'b0, total_q} + (TOT_W + 1)'(pos_full);

	// Controls to the row of cells.
	always_comb begin
		ctl.ld   = pend_q || (accept && (op == OP_INIT));
		ctl.size = new_size;
		ctl.inj  = accept && (op == OP_ACCESS) && in_range;
		ctl.key  = KEY_W'(key);
	end

	mtfl_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.hit    (chain_hit)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= RST_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// Sequencer: start, scan and report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b1;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			active_q <= clamp_size(RST_SIZE);
			total_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (pend_q) begin
				pend_q   <= 1'b0;
				active_q <= new_size;
			end else if (accept) begin
				if (op == OP_INIT) begin
					active_q <= new_size;
					total_q  <= '0;
					done_q   <= 1'b1;
				end else if (in_range) begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(1);
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (chain_hit) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					total_q <= sum[TOT_W] ? '1 : sum[TOT_W-1:0];
				end
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept && !pend_q) begin
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (busy_q && chain_hit) begin
			pos_q   <= POS_W'(pos_full);
			found_q <= 1'b1;
		end
	end

	assign done          = done_q;
	assign position_cost = pos_q;
	assign found         = found_q;
	assign total_cost    = total_q;

endmodule

`default_nettype wire

>>> design/mtfl_cell.sv
// One list cell: holds one key and swaps it with the key carried past it.
`default_nettype none

module mtfl_cell (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         ld,
	input  wire  [mtfl_pkg::KEY_W-1:0]  ld_val,
	input  wire                         tok_in,
	input  wire  [mtfl_pkg::KEY_W-1:0]  car_in,
	input  wire  [mtfl_pkg::KEY_W-1:0]  skey,
	output logic                        tok_out,
	output logic [mtfl_pkg::KEY_W-1:0]  car_out,
	output logic                        hit
);
	import mtfl_pkg::*;

	logic [KEY_W-1:0] ent_q;
	logic [KEY_W-1:0] car_q;
	logic             tok_q;
	logic             hit_q;
	logic             match;

	// The scan token stops at the cell that holds the searched key.
	assign match   = tok_q && (ent_q == skey);
	assign tok_out = tok_q && !match;
	assign car_out = ent_q;
	assign hit     = hit_q;

	// Token and hit flag are control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			hit_q <= match;
		end
	end

	// Stored key takes the carried key while the token passes, or a load value.
	always_ff @(posedge clk) begin
		car_q <= car_in;
		if (ld) begin
			ent_q <= ld_val;
		end else if (tok_q) begin
			ent_q <= car_q;
		end
	end

endmodule

`default_nettype wire

>>> design/mtfl_chain.sv
// Row of list cells with the search key register and the registered hit gather.
`default_nettype none

module mtfl_chain (
	input  wire                  clk,
	input  wire                  arst_n,
	input  mtfl_pkg::mtfl_ctl_t  ctl,
	output logic                 hit
);
	import mtfl_pkg::*;

	logic [KEY_W-1:0]       skey_q;
	logic [MAX_ITEMS-1:0]   tok;
	logic [KEY_W-1:0]       car [MAX_ITEMS];
	logic [NGRP*GRP-1:0]    hit_v;
	logic [NGRP-1:0]        grp_q;

	// The searched key is held for the whole scan.
	always_ff @(posedge clk) begin
		if (ctl.inj) begin
			skey_q <= ctl.key;
		end
	end

	// The first cell receives the new key as its carried value.
	assign tok[0] = ctl.inj;
	assign car[0] = ctl.key;

	genvar i;
	generate
		for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
			logic [KEY_W-1:0] ld_val;

			// Cells below the list size load ascending keys, the rest load zero.
			assign ld_val = (KEY_W'(i) < ctl.size) ? KEY_W'(i + 1) : '0;

			if (i < MAX_ITEMS - 1) begin : g_mid
				mtfl_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ld      (ctl.ld),
					.ld_val  (ld_val),
					.tok_in  (tok[i]),
					.car_in  (car[i]),
					.skey    (skey_q),
					.tok_out (tok[i+1]),
					.car_out (car[i+1]),
					.hit     (hit_v[i])
				);
			end else begin : g_last
				mtfl_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ld      (ctl.ld),
					.ld_val  (ld_val),
					.tok_in  (tok[i]),
					.car_in  (car[i]),
					.skey    (skey_q),
					.tok_out (),
					.car_out (),
					.hit     (hit_v[i])
				);
			end
		end

		if (NGRP * GRP > MAX_ITEMS) begin : g_pad
			assign hit_v[NGRP*GRP-1:MAX_ITEMS] = '0;
		end
	endgenerate

	// Gather the one-hot hit flags in registered groups.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else begin
			for (int g = 0; g < NGRP; g++) begin
				grp_q[g] <= |hit_v[g*GRP +: GRP];
			end
		end
	end

	assign hit = |grp_q;

endmodule

`default_nettype wire

>>> design/mtfl_checker.sv
// Port-level checks for the move-to-front list search block, with its bind.
`default_nettype none

module mtfl_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          start,
	input wire                          busy,
	input wire                          op,
	input wire                          done,
	input wire [mtfl_pkg::POS_W-1:0]    position_cost,
	input wire                          found,
	input wire [mtfl_pkg::TOT_W-1:0]    total_cost
);
	import mtfl_pkg::*;

	// A result strobe always frees the block for the next item.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A found key always has a nonzero position.
	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (position_cost != '0))
		else $error("found key reported at position zero");

	// A missed key or a reinitialize reports position zero.
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (position_cost == '0))
		else $error("nonzero position without a find");

	// A reinitialize answers in the next cycle with a cleared total.
	a_init_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_INIT)) |=> (done && !found && (total_cost == '0)))
		else $error("reinitialize did not clear the total");

	// The running total includes the cost just reported.
	a_total_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (total_cost >= TOT_W'(position_cost)))
		else $error("total below the reported cost");

endmodule

bind move_to_front_list_search mtfl_checker u_mtfl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.op            (op),
	.done          (done),
	.position_cost (position_cost),
	.found         (found),
	.total_cost    (total_cost)
);

`default_nettype wire
